@@ design/tis_pkg.sv @@
// Package of shared constants and types for the tagged interval statistics table.
`timescale 1ns / 1ps
package tis_pkg;
   localparam int NumSlots = 32;
   localparam int TagBits = 16;
   localparam int TimeBits = 48;
   localparam int SlotBits = $clog2(NumSlots);
   localparam int MeanBits = 56;
   localparam int CallBits = 32;
   localparam int NumBits = CallBits + 1;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusFull = 2'd1;
   localparam logic [1:0] StatusNoSlot = 2'd2;
   localparam logic [1:0] StatusNoBegin = 2'd3;

   localparam logic CmdBegin = 1'b0;
   localparam logic CmdEnd = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the input item, start the search
      logic scan;       // examine one slot
      logic read;       // read the chosen slot's entry
      logic div_start;  // start the mean division
      logic div_step;   // one quotient bit
      logic write;      // write the slot entry back
      logic out_load;   // load the result register
   } tis_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic found;
      logic free_found;
      logic is_end;
      logic pending;
      logic first;
      logic div_done;
      logic out_busy;
   } tis_stat_type;
endpackage

@@ design/tis_if.sv @@
// Valid/ready channel interfaces for event and result items.
`timescale 1ns / 1ps
interface tis_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [31:0] thread_id;
   logic [15:0] tag;
   logic [47:0] timestamp;
   modport source(output valid, command, thread_id, tag, timestamp, input ready);
   modport sink(input valid, command, thread_id, tag, timestamp, output ready);
endinterface

interface tis_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [4:0] slot;
   logic [47:0] elapsed;
   logic [31:0] call_count;
   logic [55:0] mean_time;
   logic [47:0] min_time;
   logic [47:0] max_time;
   modport source(output valid, status, slot, elapsed, call_count, mean_time, min_time,
      max_time, input ready);
   modport sink(input valid, status, slot, elapsed, call_count, mean_time, min_time,
      max_time, output ready);
endinterface

@@ design/tagged_interval_statistics_table.sv @@
// Top level of the tagged interval statistics table.
// Channel | Direction | Contents
// req     | in        | command, thread_id, tag, timestamp
// rsp     | out       | status, slot, elapsed, call_count, mean_time, min_time, max_time
// Items are handled one at a time; the write-back step is skipped when nothing is written,
// and the divider runs only on an end that updates an established mean; the slot search
// visits one slot per cycle and the divider produces one quotient bit per cycle.
// Reset is synchronous and clears the state, the result valid and the used and
// pending bits of the table. A stalled result holds the block before the next item.
`timescale 1ns / 1ps
module tagged_interval_statistics_table (
   input logic clock,
   input logic reset,
   tis_req_if.sink req,
   tis_rsp_if.source rsp
);
   tis_pkg::tis_cmd_type cmd;
   tis_pkg::tis_stat_type stat;

   // The controller sequences one item at a time.
   tis_controller u_ctrl (.clock, .reset, .req, .cmd, .stat);

   // The datapath holds the table and the result register.
   tis_datapath u_dp (.clock, .reset, .cmd, .stat,
      .in_command(req.command), .in_thread(req.thread_id), .in_tag(req.tag),
      .in_stamp(req.timestamp), .rsp);
endmodule

@@ design/tis_datapath.sv @@
// Datapath: slot memories, sequential search, bit-serial mean divider, result register.
`timescale 1ns / 1ps
module tis_datapath (
   input  logic clock,
   input  logic reset,
   input  tis_pkg::tis_cmd_type cmd,
   output tis_pkg::tis_stat_type stat,
   input  logic in_command,
   input  logic [31:0] in_thread,
   input  logic [15:0] in_tag,
   input  logic [47:0] in_stamp,
   tis_rsp_if.source rsp
);
   localparam int SB = tis_pkg::SlotBits;
   localparam int TB = tis_pkg::TimeBits;
   localparam int MB = tis_pkg::MeanBits;
   localparam int CB = tis_pkg::CallBits;
   localparam int GB = tis_pkg::TagBits;
   localparam int NB = tis_pkg::NumBits;

   logic [tis_pkg::NumSlots-1:0] used_ff, pend_ff;
   logic [31:0] thr_mem [tis_pkg::NumSlots];
   logic [GB-1:0] tag_mem [tis_pkg::NumSlots];
   logic [TB-1:0] stamp_mem [tis_pkg::NumSlots];
   logic [MB-1:0] mean_mem [tis_pkg::NumSlots];
   logic [TB-1:0] min_mem [tis_pkg::NumSlots];
   logic [TB-1:0] max_mem [tis_pkg::NumSlots];
   logic [CB-1:0] calls_mem [tis_pkg::NumSlots];

   logic cmd_ff;
   logic [31:0] thr_ff;
   logic [GB-1:0] tag_ff;
   logic [TB-1:0] now_ff;
   logic [SB:0] idx_ff;
   logic found_ff, free_ff;
   logic [SB-1:0] hit_ff, free_idx_ff;

   logic [SB-1:0] sel;

   logic [TB-1:0] rstamp_ff, rmin_ff, rmax_ff;
   logic [MB-1:0] rmean_ff;
   logic [CB-1:0] rcalls_ff;
   logic rpend_ff;

   // divider state
   logic [MB-1:0] dividend_ff, quot_ff;
   logic [NB-1:0] rem_ff, divisor_ff;
   logic [$clog2(MB+1)-1:0] dcnt_ff;
   logic neg_ff;
   logic [TB-1:0] el_ff;

   logic [1:0] st_ff;
   logic [4:0] slot_ff;
   logic [TB-1:0] oel_ff, omin_ff, omax_ff;
   logic [CB-1:0] ocalls_ff;
   logic [MB-1:0] omean_ff;
   logic ovalid_ff;

   logic [SB-1:0] scan_idx;
   logic [TB-1:0] el;
   logic [MB-1:0] sample;
   logic [NB:0] rem_try;
   logic [MB-1:0] new_mean;
   logic first, ok_end;
   logic [1:0] res_st;

   assign scan_idx = idx_ff[SB-1:0];
   assign sel = found_ff ? hit_ff : free_idx_ff;
   assign el = now_ff - rstamp_ff;
   // The interval is below 2^TimeBits, so the scaled sample always fits the mean.
   assign sample = {el, 8'h00};
   assign first = found_ff ? (rcalls_ff == '0) : 1'b1;
   assign ok_end = cmd_ff && found_ff && rpend_ff;
   assign rem_try = {rem_ff, dividend_ff[MB-1]} ;
   assign new_mean = neg_ff ? rmean_ff - quot_ff : rmean_ff + quot_ff;

   assign stat.scan_done = idx_ff[SB];
   assign stat.found = found_ff;
   assign stat.free_found = free_ff;
   assign stat.is_end = cmd_ff;
   assign stat.pending = rpend_ff;
   assign stat.first = first;
   assign stat.div_done = (dcnt_ff == '0);
   assign stat.out_busy = ovalid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= in_command;
         thr_ff <= in_thread;
         tag_ff <= in_tag[GB-1:0];
         now_ff <= in_stamp[TB-1:0];
         idx_ff <= '0;
         found_ff <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + 1'b1;
         if (!found_ff && used_ff[scan_idx] && thr_mem[scan_idx] == thr_ff
             && tag_mem[scan_idx] == tag_ff) begin
            found_ff <= 1'b1;
            hit_ff <= scan_idx;
         end
         if (!free_ff && !used_ff[scan_idx]) begin
            free_ff <= 1'b1;
            free_idx_ff <= scan_idx;
         end
      end
      if (cmd.read) begin
         rstamp_ff <= stamp_mem[sel];
         rmean_ff <= mean_mem[sel];
         rmin_ff <= min_mem[sel];
         rmax_ff <= max_mem[sel];
         rcalls_ff <= calls_mem[sel];
         rpend_ff <= pend_ff[sel];
      end
      if (cmd.div_start) begin
         el_ff <= el;
         neg_ff <= sample < rmean_ff;
         dividend_ff <= (sample < rmean_ff) ? rmean_ff - sample : sample - rmean_ff;
         divisor_ff <= NB'(rcalls_ff) + 1'b1;
         rem_ff <= '0;
         quot_ff <= '0;
         dcnt_ff <= ($clog2(MB+1))'(MB);
      end else if (cmd.div_step) begin
         dividend_ff <= dividend_ff << 1;
         dcnt_ff <= dcnt_ff - 1'b1;
         if (rem_try >= {1'b0, divisor_ff}) begin
            rem_ff <= NB'(rem_try - {1'b0, divisor_ff});
            quot_ff <= {quot_ff[MB-2:0], 1'b1};
         end else begin
            rem_ff <= NB'(rem_try);
            quot_ff <= {quot_ff[MB-2:0], 1'b0};
         end
      end
      if (cmd.write) begin
         if (!cmd_ff) begin
            stamp_mem[sel] <= now_ff;
            if (!found_ff) begin
               thr_mem[sel] <= thr_ff;
               tag_mem[sel] <= tag_ff;
               calls_mem[sel] <= '0;
               mean_mem[sel] <= '0;
               min_mem[sel] <= '0;
               max_mem[sel] <= '0;
            end
         end else begin
            mean_mem[sel] <= first ? sample : new_mean;
            min_mem[sel] <= (first || el_ff < rmin_ff) ? el_ff : rmin_ff;
            max_mem[sel] <= (first || el_ff > rmax_ff) ? el_ff : rmax_ff;
            if (rcalls_ff != '1) calls_mem[sel] <= rcalls_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         pend_ff <= '0;
      end else if (cmd.write) begin
         if (!cmd_ff) begin
            used_ff[sel] <= 1'b1;
            pend_ff[sel] <= 1'b1;
         end else begin
            pend_ff[sel] <= 1'b0;
         end
      end
   end

   // Result selection, loaded after the entry's final values are known. The pending
   // bit is the one captured before the write-back cleared it.
   always_comb begin
      priority if (!cmd_ff && !found_ff && !free_ff) res_st = tis_pkg::StatusFull;
      else if (cmd_ff && !found_ff) res_st = tis_pkg::StatusNoSlot;
      else if (cmd_ff && !rpend_ff) res_st = tis_pkg::StatusNoBegin;
      else res_st = tis_pkg::StatusOk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         ovalid_ff <= 1'b1;
      end else if (rsp.ready) begin
         ovalid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         st_ff <= res_st;
         if (res_st == tis_pkg::StatusFull || res_st == tis_pkg::StatusNoSlot) begin
            slot_ff <= '0; oel_ff <= '0; ocalls_ff <= '0;
            omean_ff <= '0; omin_ff <= '0; omax_ff <= '0;
         end else begin
            slot_ff <= 5'(sel);
            oel_ff <= ok_end ? el_ff : '0;
            ocalls_ff <= calls_mem[sel];
            omean_ff <= mean_mem[sel];
            omin_ff <= min_mem[sel];
            omax_ff <= max_mem[sel];
         end
      end
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.status = st_ff;
   assign rsp.slot = slot_ff;
   assign rsp.elapsed = 48'(oel_ff);
   assign rsp.call_count = ocalls_ff;
   assign rsp.mean_time = omean_ff;
   assign rsp.min_time = 48'(omin_ff);
   assign rsp.max_time = 48'(omax_ff);
endmodule

@@ design/tis_controller.sv @@
// Controller state machine sequencing search, division, write-back and result.
`timescale 1ns / 1ps
module tis_controller (
   input  logic clock,
   input  logic reset,
   tis_req_if.sink req,
   output tis_pkg::tis_cmd_type cmd,
   input  tis_pkg::tis_stat_type stat
);
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ, S_DSTART, S_DIV, S_WRITE, S_OUT, S_WAIT
   } state_type;
   state_type state_ff, state_in;
   logic do_write;

   assign req.ready = (state_ff == S_IDLE);
   assign do_write = stat.is_end ? (stat.found && stat.pending)
                                 : (stat.found || stat.free_found);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid) begin cmd.load = 1'b1; state_in = S_SCAN; end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_READ;
            else cmd.scan = 1'b1;
         end
         S_READ: begin cmd.read = 1'b1; state_in = S_DSTART; end
         S_DSTART: begin
            if (stat.is_end && stat.found && stat.pending) begin
               cmd.div_start = 1'b1;
               state_in = stat.first ? S_WRITE : S_DIV;
            end else begin
               state_in = do_write ? S_WRITE : S_WAIT;
            end
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_WRITE;
            else cmd.div_step = 1'b1;
         end
         S_WRITE: begin cmd.write = 1'b1; state_in = S_WAIT; end
         S_WAIT: if (!stat.out_busy) state_in = S_OUT;
         S_OUT: begin cmd.out_load = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

`ifndef NO_ASSERTIONS
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE) else $error("load outside idle");
   a_write_once: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> !cmd.write) else $error("double write");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !stat.out_busy) else $error("result overwritten");
`endif
endmodule
